FILE: src/scrvb_pkg.sv
// ----------------------------------------------------------------------------
// scrvb_pkg
// Shared widths, register map and saturation limits of the series comb reverb.
// ----------------------------------------------------------------------------
package scrvb_pkg;

    // sample and coefficient widths
    localparam int SAMPLE_W = 16;
    localparam int DELAY_W  = 12;
    localparam int GAIN_W   = 16;

    // configuration port
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int REG_IDX_W = 3;
    localparam int NUM_DELAYS = 4;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_DELAY_ONE     = 3'd0;
    localparam reg_idx_t REG_DELAY_TWO     = 3'd1;
    localparam reg_idx_t REG_DELAY_THREE   = 3'd2;
    localparam reg_idx_t REG_DELAY_FOUR    = 3'd3;
    localparam reg_idx_t REG_FEEDBACK_GAIN = 3'd4;

    // reset values of the registers
    localparam logic [DELAY_W-1:0] DELAY_ONE_RST   = 12'd1392;
    localparam logic [DELAY_W-1:0] DELAY_TWO_RST   = 12'd1776;
    localparam logic [DELAY_W-1:0] DELAY_THREE_RST = 12'd1968;
    localparam logic [DELAY_W-1:0] DELAY_FOUR_RST  = 12'd2064;
    localparam logic [GAIN_W-1:0]  GAIN_RST        = 16'd19661;

    // q1.15 saturation limits
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

endpackage

FILE: src/scrvb_stage.sv
// ----------------------------------------------------------------------------
// scrvb_stage
// One feedback comb stage: history ring in a synchronous memory, read into a
// register ahead of the add, scaled feedback added and saturated, result written back.
// ----------------------------------------------------------------------------
module scrvb_stage #(
    parameter int MAX_DELAY = 4096
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   advance,
    input  logic                                   tok_valid,
    input  logic signed [scrvb_pkg::SAMPLE_W-1:0]  tok_x,
    input  logic [$clog2(MAX_DELAY)-1:0]           tok_slot,
    input  logic [$clog2(MAX_DELAY+1)-1:0]         tok_seen,
    input  logic [scrvb_pkg::DELAY_W-1:0]          delay,
    input  logic [scrvb_pkg::GAIN_W-1:0]           gain,
    output logic                                   res_valid,
    output logic signed [scrvb_pkg::SAMPLE_W-1:0]  res_x,
    output logic [$clog2(MAX_DELAY)-1:0]           res_slot,
    output logic [$clog2(MAX_DELAY+1)-1:0]         res_seen
);

    localparam int AW = $clog2(MAX_DELAY);
    localparam int SW = $clog2(MAX_DELAY + 1);
    localparam int CW = ((SW > scrvb_pkg::DELAY_W) ? SW : scrvb_pkg::DELAY_W) + 1;
    localparam int XW = scrvb_pkg::SAMPLE_W;
    localparam int PW = XW + scrvb_pkg::GAIN_W + 1;

    // history ring
    logic signed [XW-1:0] hist_mem [MAX_DELAY];

    // first cycle: read issued
    logic                 v1_reg;
    logic signed [XW-1:0] x1_reg;
    logic [AW-1:0]        slot1_reg;
    logic [SW-1:0]        seen1_reg;
    logic                 hit1_reg;
    logic                 zero1_reg;
    logic                 byp1_reg;
    logic signed [XW-1:0] bypd1_reg;
    logic signed [XW-1:0] rdata_reg;

    // result token
    logic                 res_valid_reg;
    logic signed [XW-1:0] res_x_reg;
    logic [AW-1:0]        res_slot_reg;
    logic [SW-1:0]        res_seen_reg;

    logic [CW-1:0]        d_ext;
    logic [CW-1:0]        diff;
    logic [AW-1:0]        rd_addr;
    logic                 hit;
    logic signed [XW-1:0] h;
    logic signed [PW-1:0] prod;
    logic signed [XW+1:0] sum;
    logic signed [XW-1:0] y;

    // read address and history guard
    always_comb
    begin
        d_ext = CW'(delay);
        hit   = (delay != '0) && (d_ext < CW'(MAX_DELAY)) && (d_ext <= CW'(tok_seen));
        diff  = CW'(tok_slot) - d_ext;
        if (diff[CW-1])
        begin
            rd_addr = AW'(diff + CW'(MAX_DELAY));
        end
        else
        begin
            rd_addr = AW'(diff);
        end
    end

    // feedback select, scale, add and saturate
    always_comb
    begin
        if (zero1_reg)
        begin
            h = x1_reg;
        end
        else if (!hit1_reg)
        begin
            h = '0;
        end
        else if (byp1_reg)
        begin
            h = bypd1_reg;
        end
        else
        begin
            h = rdata_reg;
        end
        prod = PW'(h) * PW'($signed({1'b0, gain}));
        sum  = $signed({{2{x1_reg[XW-1]}}, x1_reg})
             + $signed({prod[PW-1], prod[PW-1:scrvb_pkg::GAIN_W]});
        if (sum > (XW+2)'(scrvb_pkg::SAT_MAX))
        begin
            y = scrvb_pkg::SAT_MAX;
        end
        else if (sum < (XW+2)'(scrvb_pkg::SAT_MIN))
        begin
            y = scrvb_pkg::SAT_MIN;
        end
        else
        begin
            y = sum[XW-1:0];
        end
    end

    // memory read and write back
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rdata_reg <= hist_mem[rd_addr];
            if (v1_reg)
            begin
                hist_mem[slot1_reg] <= y;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= tok_valid;
            res_valid_reg <= v1_reg;
        end
    end

    // payload, with forwarding of the entry written in the same cycle
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x1_reg       <= tok_x;
            slot1_reg    <= tok_slot;
            seen1_reg    <= tok_seen;
            hit1_reg     <= hit;
            zero1_reg    <= (delay == '0);
            byp1_reg     <= v1_reg && (slot1_reg == rd_addr);
            bypd1_reg    <= y;
            res_x_reg    <= y;
            res_slot_reg <= slot1_reg;
            res_seen_reg <= seen1_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_x     = res_x_reg;
    assign res_slot  = res_slot_reg;
    assign res_seen  = res_seen_reg;

endmodule

FILE: src/series_comb_reverb_core.sv
// ----------------------------------------------------------------------------
// series_comb_reverb_core
// Cascade of feedback comb stages over q1.15 samples with apb configuration.
// ----------------------------------------------------------------------------
// throughput: one word per cycle unless the sink stalls a finished word; each stage
// reads its history memory as a word enters and writes back as the word moves on,
// with forwarding of the newest entry
// reset: async, clears registers to their defaults, ring position and sample
// count; history memories are not cleared, reads before a buffer start give 0
module series_comb_reverb_core #(
    parameter int MAX_DELAY = 4096,
    parameter int STAGES    = 4
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [scrvb_pkg::ADDR_W-1:0]           paddr,
    input  logic [scrvb_pkg::DATA_W-1:0]           pwdata,
    output logic [scrvb_pkg::DATA_W-1:0]           prdata,
    output logic                                   pready,
    // sample input
    input  logic                                   req_valid,
    output logic                                   req_stall,
    input  logic signed [scrvb_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic                                   buffer_start,
    // sample output
    output logic                                   rsp_valid,
    input  logic                                   rsp_stall,
    output logic signed [scrvb_pkg::SAMPLE_W-1:0]  sample_out
);

    localparam int AW = $clog2(MAX_DELAY);
    localparam int SW = $clog2(MAX_DELAY + 1);
    localparam int XW = scrvb_pkg::SAMPLE_W;

    logic [scrvb_pkg::DELAY_W-1:0] delay_reg [scrvb_pkg::NUM_DELAYS];
    logic [scrvb_pkg::GAIN_W-1:0]  gain_reg;
    logic [AW-1:0]                 slot_reg;
    logic [SW-1:0]                 seen_reg;
    logic                          rsp_valid_reg;
    logic signed [XW-1:0]          sample_out_reg;

    logic                          cfg_write;
    scrvb_pkg::reg_idx_t           cfg_idx;
    logic                          advance;
    logic                          accept;
    logic [SW-1:0]                 seen_cur;
    logic [AW-1:0]                 slot_next;
    logic [SW-1:0]                 seen_next;

    logic                 tok_valid [STAGES+1];
    logic signed [XW-1:0] tok_x     [STAGES+1];
    logic [AW-1:0]        tok_slot  [STAGES+1];
    logic [SW-1:0]        tok_seen  [STAGES+1];

    // apb decode
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[scrvb_pkg::ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg[0] <= scrvb_pkg::DELAY_ONE_RST;
            delay_reg[1] <= scrvb_pkg::DELAY_TWO_RST;
            delay_reg[2] <= scrvb_pkg::DELAY_THREE_RST;
            delay_reg[3] <= scrvb_pkg::DELAY_FOUR_RST;
            gain_reg     <= scrvb_pkg::GAIN_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                scrvb_pkg::REG_DELAY_ONE:     delay_reg[0] <= pwdata[scrvb_pkg::DELAY_W-1:0];
                scrvb_pkg::REG_DELAY_TWO:     delay_reg[1] <= pwdata[scrvb_pkg::DELAY_W-1:0];
                scrvb_pkg::REG_DELAY_THREE:   delay_reg[2] <= pwdata[scrvb_pkg::DELAY_W-1:0];
                scrvb_pkg::REG_DELAY_FOUR:    delay_reg[3] <= pwdata[scrvb_pkg::DELAY_W-1:0];
                scrvb_pkg::REG_FEEDBACK_GAIN: gain_reg     <= pwdata[scrvb_pkg::GAIN_W-1:0];
                default:                      ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (cfg_idx)
            scrvb_pkg::REG_DELAY_ONE:     prdata = scrvb_pkg::DATA_W'(delay_reg[0]);
            scrvb_pkg::REG_DELAY_TWO:     prdata = scrvb_pkg::DATA_W'(delay_reg[1]);
            scrvb_pkg::REG_DELAY_THREE:   prdata = scrvb_pkg::DATA_W'(delay_reg[2]);
            scrvb_pkg::REG_DELAY_FOUR:    prdata = scrvb_pkg::DATA_W'(delay_reg[3]);
            scrvb_pkg::REG_FEEDBACK_GAIN: prdata = scrvb_pkg::DATA_W'(gain_reg);
            default:                      prdata = '0;
        endcase
    end

    // pipeline moves unless a finished word is held by the sink
    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !advance;
    assign accept    = req_valid && advance;

    // ring position and buffer sample count
    always_comb
    begin
        seen_cur  = buffer_start ? '0 : seen_reg;
        slot_next = (slot_reg == AW'(MAX_DELAY - 1)) ? '0 : slot_reg + AW'(1);
        seen_next = (seen_cur < SW'(MAX_DELAY)) ? seen_cur + SW'(1) : SW'(MAX_DELAY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            seen_reg <= '0;
        end
        else if (accept)
        begin
            slot_reg <= slot_next;
            seen_reg <= seen_next;
        end
    end

    // stage cascade
    assign tok_valid[0] = accept;
    assign tok_x[0]     = sample_in;
    assign tok_slot[0]  = slot_reg;
    assign tok_seen[0]  = seen_cur;

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        scrvb_stage #(
            .MAX_DELAY (MAX_DELAY)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .tok_valid (tok_valid[k]),
            .tok_x     (tok_x[k]),
            .tok_slot  (tok_slot[k]),
            .tok_seen  (tok_seen[k]),
            .delay     (delay_reg[k % scrvb_pkg::NUM_DELAYS]),
            .gain      (gain_reg),
            .res_valid (tok_valid[k+1]),
            .res_x     (tok_x[k+1]),
            .res_slot  (tok_slot[k+1]),
            .res_seen  (tok_seen[k+1])
        );
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= tok_valid[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sample_out_reg <= tok_x[STAGES];
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign sample_out = sample_out_reg;

endmodule

FILE: tb/sv/tb_series_comb_reverb_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_series_comb_reverb_check
// Watches the sample and configuration channels of the comb reverb core.
// Keeps its own copy of the registers and of one echo ring per stage and works out
// each output word from every accepted input word. Each returned word is
// compared with the oldest one still due. Mismatches are reported and counted.
// ----------------------------------------------------------------------------
module tb_series_comb_reverb_check #(
    parameter int MAX_DELAY = 4096,
    parameter int STAGES    = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic                                  pready,
    input  logic [scrvb_pkg::ADDR_W-1:0]          paddr,
    input  logic [scrvb_pkg::DATA_W-1:0]          pwdata,
    input  logic                                  req_valid,
    input  logic                                  req_stall,
    input  logic signed [scrvb_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                                  buffer_start,
    input  logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    input  logic signed [scrvb_pkg::SAMPLE_W-1:0] sample_out,
    output int                                    errors,
    output int                                    pending
);

    // shadow registers
    logic [scrvb_pkg::DELAY_W-1:0] tap_delay [scrvb_pkg::NUM_DELAYS];
    logic [scrvb_pkg::GAIN_W-1:0]  fb_gain;
    scrvb_pkg::reg_idx_t           reg_sel;

    // shadow echo rings, ring position and fill count of the current buffer
    logic signed [scrvb_pkg::SAMPLE_W-1:0] echo_mem [STAGES][MAX_DELAY];
    int                                    ring_pos;
    int                                    fill_count;

    // output words still due, oldest first
    logic signed [scrvb_pkg::SAMPLE_W-1:0] echo_due [$];
    logic signed [scrvb_pkg::SAMPLE_W-1:0] want;
    int                                    words_out;

    initial
    begin
        errors    = 0;
        pending   = 0;
        words_out = 0;
    end

    task report_mismatch(input string what);
        $display("mismatch at output word %0d: %s", words_out, what);
        errors++;
    endtask

    // one sample through the cascade, updating the rings
    function automatic logic signed [scrvb_pkg::SAMPLE_W-1:0] comb_cascade(
        input logic signed [scrvb_pkg::SAMPLE_W-1:0] dry,
        input logic                                  first
    );
        int     x;
        int     y;
        int     h;
        int     d;
        int     seen;
        longint wet;
        seen = first ? 0 : fill_count;
        x    = dry;
        for (int k = 0; k < STAGES; k++)
        begin
            d = tap_delay[k % scrvb_pkg::NUM_DELAYS];
            h = 0;
            // zero delay feeds back the stage input itself
            if (d == 0)
                h = x;
            else if (d < MAX_DELAY && d <= seen)
                h = echo_mem[k][(ring_pos + MAX_DELAY - d) % MAX_DELAY];
            // arithmetic shift rounds toward minus infinity
            wet = (longint'(h) * longint'(fb_gain)) >>> 16;
            y   = x + int'(wet);
            if (y > scrvb_pkg::SAT_MAX)
                y = scrvb_pkg::SAT_MAX;
            else if (y < scrvb_pkg::SAT_MIN)
                y = scrvb_pkg::SAT_MIN;
            echo_mem[k][ring_pos] = y[scrvb_pkg::SAMPLE_W-1:0];
            x = y;
        end
        ring_pos   = (ring_pos + 1) % MAX_DELAY;
        fill_count = (seen < MAX_DELAY) ? seen + 1 : MAX_DELAY;
        return x[scrvb_pkg::SAMPLE_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_delay[0] = scrvb_pkg::DELAY_ONE_RST;
            tap_delay[1] = scrvb_pkg::DELAY_TWO_RST;
            tap_delay[2] = scrvb_pkg::DELAY_THREE_RST;
            tap_delay[3] = scrvb_pkg::DELAY_FOUR_RST;
            fb_gain      = scrvb_pkg::GAIN_RST;
            ring_pos     = 0;
            fill_count   = 0;
            echo_due.delete();
            pending      = 0;
        end
        else
        begin
            // register writes; unmapped slots are ignored
            if (psel && penable && pwrite && pready)
            begin
                reg_sel = paddr[scrvb_pkg::ADDR_W-1:2];
                if (reg_sel < scrvb_pkg::NUM_DELAYS)
                    tap_delay[reg_sel[1:0]] = pwdata[scrvb_pkg::DELAY_W-1:0];
                else if (reg_sel == scrvb_pkg::REG_FEEDBACK_GAIN)
                    fb_gain = pwdata[scrvb_pkg::GAIN_W-1:0];
            end

            // returned word against the oldest one due
            if (rsp_valid && !rsp_stall)
            begin
                if (echo_due.size() == 0)
                    report_mismatch($sformatf("unexpected word %0d", sample_out));
                else
                begin
                    want = echo_due.pop_front();
                    if (sample_out !== want)
                        report_mismatch($sformatf("sample_out %0d, want %0d",
                                                  sample_out, want));
                end
                words_out++;
            end

            // accepted word
            if (req_valid && !req_stall)
                echo_due.push_back(comb_cascade(sample_in, buffer_start));

            pending = echo_due.size();
        end
    end

endmodule

FILE: tb/sv/tb_series_comb_reverb_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_series_comb_reverb_core
// Drives the comb reverb core with directed and random sample words under
// several register settings, with random gaps on both channels and one long
// output hold-off. Prediction and comparison sit in the checker beside it.
// ----------------------------------------------------------------------------
module tb_series_comb_reverb_core;

    localparam int MAX_DELAY    = 4096;
    localparam int STAGES       = 4;
    localparam int DELAY_TOP    = (1 << scrvb_pkg::DELAY_W) - 1;
    localparam int GAIN_TOP     = (1 << scrvb_pkg::GAIN_W) - 1;
    localparam int DRAIN_CYCLES = 2 * STAGES + 12;
    localparam int HOLD_CYCLES  = 150;
    localparam int QUIET_LIMIT  = 2000;
    localparam scrvb_pkg::reg_idx_t REG_SPARE = 3'd5;

    logic                                  clk = 1'b0;
    logic                                  rst_n;
    logic                                  psel;
    logic                                  penable;
    logic                                  pwrite;
    logic [scrvb_pkg::ADDR_W-1:0]          paddr;
    logic [scrvb_pkg::DATA_W-1:0]          pwdata;
    logic [scrvb_pkg::DATA_W-1:0]          prdata;
    logic                                  pready;
    logic                                  req_valid;
    logic                                  req_stall;
    logic signed [scrvb_pkg::SAMPLE_W-1:0] sample_in;
    logic                                  buffer_start;
    logic                                  rsp_valid;
    logic                                  rsp_stall;
    logic signed [scrvb_pkg::SAMPLE_W-1:0] sample_out;

    int errors;
    int pending;
    int send_gap_pct;
    int recv_gap_pct;
    int hold_asked;
    int hold_taken;
    int hold_left;
    int quiet_cycles;

    series_comb_reverb_core #(
        .MAX_DELAY (MAX_DELAY),
        .STAGES    (STAGES)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .sample_in    (sample_in),
        .buffer_start (buffer_start),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .sample_out   (sample_out)
    );

    tb_series_comb_reverb_check #(
        .MAX_DELAY (MAX_DELAY),
        .STAGES    (STAGES)
    ) echo_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .sample_in    (sample_in),
        .buffer_start (buffer_start),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .sample_out   (sample_out),
        .errors       (errors),
        .pending      (pending)
    );

    // clock
    always #5 clk = ~clk;

    // output side: random stalls, or a long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_asked != hold_taken)
        begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99, 0) < recv_gap_pct);
    end

    // watchdog on cycles with no handshake of any kind
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // one word offered until accepted, after a random gap
    task automatic put_word(input logic signed [scrvb_pkg::SAMPLE_W-1:0] value,
                            input logic first);
        while ($urandom_range(99, 0) < send_gap_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid    <= 1'b1;
        sample_in    <= value;
        buffer_start <= first;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // input stopped and every output word returned
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // register write; bits above the field width carry random junk
    task automatic apb_write(input scrvb_pkg::reg_idx_t idx, input int unsigned value,
                             input int width);
        logic [scrvb_pkg::DATA_W-1:0] word;
        word = $urandom;
        for (int b = 0; b < width; b++)
            word[b] = value[b];
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_taps(input int d1, input int d2, input int d3, input int d4,
                            input int gain);
        wait_idle();
        apb_write(scrvb_pkg::REG_DELAY_ONE,     d1,   scrvb_pkg::DELAY_W);
        apb_write(scrvb_pkg::REG_DELAY_TWO,     d2,   scrvb_pkg::DELAY_W);
        apb_write(scrvb_pkg::REG_DELAY_THREE,   d3,   scrvb_pkg::DELAY_W);
        apb_write(scrvb_pkg::REG_DELAY_FOUR,    d4,   scrvb_pkg::DELAY_W);
        apb_write(scrvb_pkg::REG_FEEDBACK_GAIN, gain, scrvb_pkg::GAIN_W);
    endtask

    // full scale now and then, quiet material often, otherwise any value
    function automatic logic signed [scrvb_pkg::SAMPLE_W-1:0] pick_sample();
        int roll;
        int quiet;
        roll  = $urandom_range(99, 0);
        quiet = $urandom_range(4000, 0);
        if (roll < 5)
            return scrvb_pkg::SAT_MAX;
        if (roll < 10)
            return scrvb_pkg::SAT_MIN;
        if (roll < 35)
            return scrvb_pkg::SAMPLE_W'(quiet - 2000);
        return scrvb_pkg::SAMPLE_W'($urandom);
    endfunction

    task automatic play(input int count, input int start_pct);
        for (int i = 0; i < count; i++)
            put_word(pick_sample(), $urandom_range(99, 0) < start_pct);
    endtask

    // short delays mostly, some with the full delay range or its ends
    task automatic random_phase(input int p);
        int d [scrvb_pkg::NUM_DELAYS];
        int g;
        for (int k = 0; k < scrvb_pkg::NUM_DELAYS; k++)
        begin
            if (p % 5 == 3)
                d[k] = $urandom_range(DELAY_TOP, 0);
            else if (p % 5 == 4)
                d[k] = $urandom_range(1, 0) ? DELAY_TOP : 0;
            else
                d[k] = $urandom_range(12, 0);
        end
        case (p % 4)
            0:       g = GAIN_TOP;
            1:       g = 0;
            default: g = $urandom_range(GAIN_TOP, 0);
        endcase
        set_taps(d[0], d[1], d[2], d[3], g);
        play($urandom_range(60, 35), 3);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_valid    = 1'b0;
        sample_in    = '0;
        buffer_start = 1'b0;
        rsp_stall    = 1'b0;
        send_gap_pct = 31;
        recv_gap_pct = 66;
        hold_asked   = 0;
        hold_taken   = 0;
        hold_left    = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings, no buffer start yet so no history
        put_word(scrvb_pkg::SAT_MAX, 1'b0);
        put_word(scrvb_pkg::SAT_MIN, 1'b0);
        put_word(16'sd0,             1'b0);

        // zero, one- and two-sample delays at full gain
        set_taps(0, 1, 0, 2, GAIN_TOP);
        put_word(scrvb_pkg::SAT_MAX, 1'b1);
        put_word(scrvb_pkg::SAT_MAX, 1'b0);
        put_word(scrvb_pkg::SAT_MIN, 1'b0);
        put_word(scrvb_pkg::SAT_MIN, 1'b0);
        put_word(-16'sd1,            1'b0);
        put_word(16'sd1,             1'b0);
        put_word(16'sh5555,          1'b0);
        put_word(16'shaaaa,          1'b0);
        put_word(scrvb_pkg::SAT_MAX, 1'b1);
        put_word(16'sd0,             1'b0);
        put_word(scrvb_pkg::SAT_MIN, 1'b0);

        // longest, zero and one-sample delays with no feedback, and a write to an unmapped slot
        set_taps(DELAY_TOP, 0, DELAY_TOP, 1, 0);
        apb_write(REG_SPARE, $urandom, scrvb_pkg::DATA_W);
        put_word(scrvb_pkg::SAT_MIN, 1'b1);
        put_word(scrvb_pkg::SAT_MAX, 1'b0);
        put_word(-16'sd1,            1'b0);
        put_word(16'sh7ffe,          1'b0);
        put_word(16'sh8001,          1'b0);

        // sender idles little, receiver often
        for (int p = 0; p < 5; p++)
            random_phase(p);

        // receiver holds off while the sender keeps offering words
        send_gap_pct = 0;
        hold_asked   = hold_asked + 1;
        play(40, 3);

        // sender idles often, receiver little
        send_gap_pct = 66;
        recv_gap_pct = 31;
        for (int p = 5; p < 10; p++)
            random_phase(p);

        // no idling: one unbroken buffer over long and short delays, then more random phases
        send_gap_pct = 0;
        recv_gap_pct = 0;
        set_taps(DELAY_TOP, 3, 0, DELAY_TOP, $urandom_range(GAIN_TOP, 0));
        put_word(pick_sample(), 1'b1);
        play(60, 0);
        for (int p = 10; p < 14; p++)
            random_phase(p);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: series_comb_reverb_core.f
src/scrvb_pkg.sv
src/scrvb_stage.sv
src/series_comb_reverb_core.sv
tb/sv/tb_series_comb_reverb_check.sv
tb/sv/tb_series_comb_reverb_core.sv
